/* rtl/core/lgge_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and constants of the life grid generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

    localparam int LANE_W        = 32;  // columns held in one row cell
    localparam int STORE_ROWS    = 32;  // most rows the ring can hold
    localparam int GRID_SIZE_DEF = 32;
    localparam int SIZE_W        = 6;
    localparam int COORD_W       = 5;
    localparam int CNT_W         = 4;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
    localparam logic [CNT_W-1:0] KEEP_LOW    = 4'd2;
    localparam logic [CNT_W-1:0] KEEP_HIGH   = 4'd3;

    localparam logic [SIZE_W-1:0] ACTIVE_SIZE_RST = 6'd21;

    // register index, taken from paddr[2]
    localparam logic REG_ACTIVE_SIZE = 1'b0;

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_STEP  = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    // control broadcast to every row cell
    typedef struct packed {
        logic               shift;
        logic               clear;
        logic               set;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } cell_ctrl_t;

endpackage

/* rtl/core/life_grid_generation_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_engine_top
// Life grid engine: a ring of row cells that rotates once per generation.
// ----------------------------------------------------------------------------
// Set, clear and read words: the result is registered in the output slot, or
// in the skid slot while the output stalls. Advance: the row ring rotates once
// over min(GRID_SIZE,32) rows in ST_SWEEP, and ST_DONE posts the result word.
// Throughput is one word at a time; the rotation loop sets the advance rate.
// Reset: all cells dead, active_size 21, both result slots empty.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_top #(
    parameter int GRID_SIZE = lgge_pkg::GRID_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lgge_pkg::PADDR_W-1:0]  paddr,
    input  logic [lgge_pkg::PDATA_W-1:0]  pwdata,
    output logic [lgge_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [lgge_pkg::COORD_W-1:0]  row,
    input  logic [lgge_pkg::COORD_W-1:0]  col,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [lgge_pkg::LANE_W-1:0]   row_bits,
    output logic                          in_range
);
    import lgge_pkg::*;

    // rows actually stored: the grid never exceeds the 32-bit row word
    localparam int ROWS  = (GRID_SIZE < STORE_ROWS) ? GRID_SIZE : STORE_ROWS;
    localparam int IDX_W = $clog2(ROWS);
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ROWS - 1);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(ROWS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] active_size_reg;
    logic              cfg_wr;
    logic [SIZE_W-1:0] size_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == REG_ACTIVE_SIZE);
    // reads with nonzero byte-lane address bits return zero
    assign prdata = (paddr[2] == REG_ACTIVE_SIZE && paddr[1:0] == 2'b00)
                    ? PDATA_W'(active_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_size_reg <= ACTIVE_SIZE_RST;
        end
        else if (cfg_wr)
        begin
            active_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // sizes above the store act as the store size
    assign size_eff = (active_size_reg > SIZE_MAX) ? SIZE_MAX : active_size_reg;

    // ------------------------------------------------------------------
    // Control state and result slots
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic [LANE_W-1:0] out_bits_reg, out_bits_next;
    logic              out_ok_reg, out_ok_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [LANE_W-1:0] skid_bits_reg, skid_bits_next;
    logic              skid_ok_reg, skid_ok_next;

    logic              accept;
    req_t              req;
    logic              row_ok;
    logic              col_ok;
    logic              res_valid;
    logic [LANE_W-1:0] res_bits;
    logic              res_ok;
    logic              out_free;
    logic [LANE_W-1:0] read_row;
    logic [LANE_W-1:0] read_mask;

    assign req      = req_t'(req_type);
    assign in_stall = (state_reg != ST_IDLE) || skid_valid_reg;
    assign accept   = in_valid && !in_stall;
    assign row_ok   = {1'b0, row} < size_eff;
    assign col_ok   = {1'b0, col} < size_eff;
    assign out_free = !out_valid_reg || !out_stall;

    // ------------------------------------------------------------------
    // Row ring: cell k holds row k whenever the engine is idle
    // ------------------------------------------------------------------
    cell_ctrl_t        ctrl;
    logic [LANE_W-1:0] cell_q [ROWS];
    logic [LANE_W-1:0] prev_reg;
    logic [LANE_W-1:0] head_new;
    logic              row_en;

    assign ctrl.shift = (state_reg == ST_SWEEP);
    assign ctrl.clear = accept && (req == REQ_CLEAR);
    assign ctrl.set   = accept && (req == REQ_SET) && row_ok && col_ok;
    assign ctrl.row   = row;
    assign ctrl.col   = col;

    for (genvar k = 0; k < ROWS; k++)
    begin : g_cell
        if (k == ROWS - 1)
        begin : g_tail
            // the updated head row re-enters at the tail
            lgge_row_cell #(.IDX(k)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .shift_in (head_new),
                .row_q    (cell_q[k])
            );
        end
        else
        begin : g_body
            lgge_row_cell #(.IDX(k)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .shift_in (cell_q[k+1]),
                .row_q    (cell_q[k])
            );
        end
    end

    // hold the old head row: it is the row above the next head
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            prev_reg <= cell_q[0];
        end
    end

    // head row is step_reg; only interior rows change
    assign row_en = (step_reg != '0)
                    && ((7'(step_reg) + 7'd1) < {1'b0, size_eff});

    lgge_rule u_rule (
        .up      (prev_reg),
        .mid     (cell_q[0]),
        .dn      (cell_q[1]),
        .size    (size_eff),
        .row_en  (row_en),
        .new_row (head_new)
    );

    // ------------------------------------------------------------------
    // Row read: select the addressed cell, drop columns beyond the size
    // ------------------------------------------------------------------
    always_comb
    begin
        read_row = '0;
        for (int k = 0; k < ROWS; k++)
        begin
            if (row == COORD_W'(k))
            begin
                read_row = cell_q[k];
            end
        end
        for (int k = 0; k < LANE_W; k++)
        begin
            read_mask[k] = SIZE_W'(k) < size_eff;
        end
    end

    // ------------------------------------------------------------------
    // Next state and result routing
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        res_valid  = 1'b0;
        res_bits   = '0;
        res_ok     = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        REQ_SET:
                        begin
                            res_valid = 1'b1;
                            res_ok    = row_ok && col_ok;
                        end
                        REQ_CLEAR:
                        begin
                            res_valid = 1'b1;
                        end
                        REQ_STEP:
                        begin
                            state_next = ST_SWEEP;
                            step_next  = '0;
                        end
                        REQ_READ:
                        begin
                            res_valid = 1'b1;
                            res_ok    = row_ok;
                            res_bits  = row_ok ? (read_row & read_mask) : '0;
                        end
                        default:
                        begin
                            res_valid = 1'b0;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                // advance the ring one row per cycle
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_DONE:
            begin
                // hold the finish until a result slot is free
                if (!skid_valid_reg)
                begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next  = out_valid_reg;
        out_bits_next   = out_bits_reg;
        out_ok_next     = out_ok_reg;
        skid_valid_next = skid_valid_reg;
        skid_bits_next  = skid_bits_reg;
        skid_ok_next    = skid_ok_reg;

        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid word first; no new result can arrive now
                out_valid_next  = 1'b1;
                out_bits_next   = skid_bits_reg;
                out_ok_next     = skid_ok_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_bits_next  = res_bits;
                out_ok_next    = res_ok;
            end
        end
        else if (res_valid)
        begin
            // park the word behind the stalled output
            skid_valid_next = 1'b1;
            skid_bits_next  = res_bits;
            skid_ok_next    = res_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_bits_reg   <= '0;
            out_ok_reg     <= 1'b0;
            skid_valid_reg <= 1'b0;
            skid_bits_reg  <= '0;
            skid_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            out_bits_reg   <= out_bits_next;
            out_ok_reg     <= out_ok_next;
            skid_valid_reg <= skid_valid_next;
            skid_bits_reg  <= skid_bits_next;
            skid_ok_reg    <= skid_ok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_bits  = out_bits_reg;
    assign in_range  = out_ok_reg;

endmodule

/* rtl/core/lgge_row_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_row_cell
// One grid row: cleared, set bit by bit, or loaded from the next cell.
// ----------------------------------------------------------------------------
module lgge_row_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lgge_pkg::cell_ctrl_t       ctrl,
    input  logic [lgge_pkg::LANE_W-1:0] shift_in,
    output logic [lgge_pkg::LANE_W-1:0] row_q
);
    import lgge_pkg::*;

    logic [LANE_W-1:0] row_reg;
    logic [LANE_W-1:0] row_next;

    always_comb
    begin
        row_next = row_reg;
        if (ctrl.clear)
        begin
            row_next = '0;
        end
        else if (ctrl.shift)
        begin
            row_next = shift_in;
        end
        else if (ctrl.set && (ctrl.row == COORD_W'(IDX)))
        begin
            row_next = row_reg | (LANE_W'(1) << ctrl.col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_q = row_reg;

endmodule

/* rtl/core/lgge_rule.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgge_rule
// B3/S23 update of one row from the old rows above, at and below it.
// ----------------------------------------------------------------------------
module lgge_rule (
    input  logic [lgge_pkg::LANE_W-1:0] up,
    input  logic [lgge_pkg::LANE_W-1:0] mid,
    input  logic [lgge_pkg::LANE_W-1:0] dn,
    input  logic [lgge_pkg::SIZE_W-1:0] size,
    input  logic                        row_en,
    output logic [lgge_pkg::LANE_W-1:0] new_row
);
    import lgge_pkg::*;

    logic [LANE_W+1:0] up_p;
    logic [LANE_W+1:0] mid_p;
    logic [LANE_W+1:0] dn_p;
    logic [LANE_W-1:0] life;
    logic [LANE_W-1:0] col_mask;
    logic [CNT_W-1:0]  cnt [LANE_W];

    // pad with dead columns so the edge lanes need no special case
    assign up_p  = {1'b0, up,  1'b0};
    assign mid_p = {1'b0, mid, 1'b0};
    assign dn_p  = {1'b0, dn,  1'b0};

    always_comb
    begin
        for (int j = 0; j < LANE_W; j++)
        begin
            cnt[j] = CNT_W'(up_p[j]) + CNT_W'(up_p[j+1]) + CNT_W'(up_p[j+2])
                   + CNT_W'(mid_p[j]) + CNT_W'(mid_p[j+2])
                   + CNT_W'(dn_p[j]) + CNT_W'(dn_p[j+1]) + CNT_W'(dn_p[j+2]);
            if (mid[j])
            begin
                life[j] = (cnt[j] >= KEEP_LOW) && (cnt[j] <= KEEP_HIGH);
            end
            else
            begin
                life[j] = (cnt[j] == BIRTH_COUNT);
            end
            // interior columns only
            col_mask[j] = row_en && (j != 0)
                          && ((7'(j) + 7'd1) < {1'b0, size});
        end
    end

    assign new_row = (mid & ~col_mask) | (life & col_mask);

endmodule

/* dv/life_grid_generation_engine_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_engine_checker
// Watches the request, result and register channels of the life grid engine.
// It keeps its own copy of the cell grid and the active size, works out the
// reply to every accepted request word, and compares each result word with
// the oldest reply still owed.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_checker #(
    parameter int GRID_SIZE = lgge_pkg::GRID_SIZE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [lgge_pkg::PADDR_W-1:0]  paddr,
    input  logic [lgge_pkg::PDATA_W-1:0]  pwdata,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [lgge_pkg::COORD_W-1:0]  row,
    input  logic [lgge_pkg::COORD_W-1:0]  col,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [lgge_pkg::LANE_W-1:0]   row_bits,
    input  logic                          in_range,
    output int                            fail_count,
    output int                            replies_due
);

    import lgge_pkg::*;

    typedef struct packed {
        logic [LANE_W-1:0] bits;
        logic              ok;
    } grid_reply_t;

    logic [LANE_W-1:0]  cells [STORE_ROWS];
    logic [SIZE_W-1:0]  side_reg;
    grid_reply_t        reply_q [$];
    grid_reply_t        oldest;
    grid_reply_t        fresh;

    function automatic int live_side();
        int n;
        n = int'(side_reg);
        if (n > GRID_SIZE) n = GRID_SIZE;
        if (n > STORE_ROWS) n = STORE_ROWS;
        return n;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
        fail_count++;
    endtask

    // B3/S23 over the interior, reading only from a copy of the old grid
    task automatic next_generation();
        logic [LANE_W-1:0] snap [STORE_ROWS];
        int                n;
        int                cnt;
        logic              alive;
        logic              keep;
        n = live_side();
        snap = cells;
        if (n < 3) return;
        for (int i = 1; i + 1 < n; i++) begin
            for (int j = 1; j + 1 < n; j++) begin
                cnt = 0;
                alive = snap[i][j];
                for (int di = -1; di <= 1; di++)
                    for (int dj = -1; dj <= 1; dj++)
                        cnt += snap[i + di][j + dj];
                cnt -= alive;
                if (alive)
                    keep = (cnt >= KEEP_LOW) && (cnt <= KEEP_HIGH);
                else
                    keep = (cnt == BIRTH_COUNT);
                cells[i][j] = keep;
            end
        end
    endtask

    task automatic predict_reply(input req_t kind, input int r, input int c,
                                 output grid_reply_t rep);
        int          n;
        logic [32:0] mask;
        n = live_side();
        rep.bits = '0;
        rep.ok = 1'b1;
        case (kind)
            REQ_SET: begin
                if (r < n && c < n) cells[r][c] = 1'b1;
                else rep.ok = 1'b0;
            end
            REQ_CLEAR: begin
                for (int k = 0; k < STORE_ROWS; k++) cells[k] = '0;
            end
            REQ_STEP: next_generation();
            default: begin
                if (r < n) begin
                    mask = (33'd1 << n) - 33'd1;
                    rep.bits = cells[r] & mask[LANE_W-1:0];
                end else begin
                    rep.ok = 1'b0;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STORE_ROWS; k++) cells[k] = '0;
            side_reg = ACTIVE_SIZE_RST;
            reply_q.delete();
            fail_count = 0;
            replies_due = 0;
        end
        else
        begin
            // compare before predicting: a word accepted now cannot answer itself
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                    report_mismatch("unrequested word", row_bits, '0);
                else
                begin
                    oldest = reply_q.pop_front();
                    if (row_bits !== oldest.bits)
                        report_mismatch("row_bits", row_bits, oldest.bits);
                    if (in_range !== oldest.ok)
                        report_mismatch("in_range", 32'(in_range), 32'(oldest.ok));
                end
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_ACTIVE_SIZE)
                side_reg = pwdata[SIZE_W-1:0];
            if (in_valid && !in_stall)
            begin
                predict_reply(req_t'(req_type), int'(row), int'(col), fresh);
                reply_q.push_back(fresh);
            end
            replies_due = reply_q.size();
        end
    end

endmodule

/* dv/tb_life_grid_generation_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_grid_generation_engine_top
// Stimulus and verdict for the life grid generation engine.
// A short directed run at the reset size seeds a glider, pokes the corners
// and the out-of-range coordinates, then a series of phases rewrites the
// active size (extremes included) and fires random set, read, advance and
// clear words with random idling on both channels. The checker beside the
// block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_life_grid_generation_engine_top;

    import lgge_pkg::*;

    localparam int IDLE_LIMIT   = 2000;  // cycles with no traffic at all
    localparam int DRAIN_CYCLES = 40;    // longer than one advance pass
    localparam int PHASE_WORDS  = 150;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           req_type = '0;
    logic [COORD_W-1:0]   row      = '0;
    logic [COORD_W-1:0]   col      = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [LANE_W-1:0]    row_bits;
    logic                 in_range;

    int                   fail_count;
    int                   replies_due;
    int                   idle_cycles = 0;
    bit                   calm = 1'b0;   // set: neither side idles
    int                   live_n = 21;   // effective side the stimulus aims at

    life_grid_generation_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .row       (row),
        .col       (col),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_bits  (row_bits),
        .in_range  (in_range)
    );

    life_grid_generation_engine_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .row         (row),
        .col         (col),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .row_bits    (row_bits),
        .in_range    (in_range),
        .fail_count  (fail_count),
        .replies_due (replies_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver side: stall about a third of the time, never while calm.
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 35);
        end
    end

    // Watchdog: any accepted request word, taken result word or psel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request word and hold it until the block takes it.
    task automatic send_request(input req_t kind, input int r, input int c);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        row      <= COORD_W'(r);
        col      <= COORD_W'(c);
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drop valid and wait for every owed result word.
    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due != 0) @(negedge clk);
    endtask

    // Setup then access cycle; upper data bits carry junk the block must drop.
    task automatic write_size(input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ACTIVE_SIZE, 2'b00};
        pwdata  <= ($urandom() & ~32'h3f) | PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly in-range coordinates, with the odd stray anywhere in the field.
    function automatic int pick_coord(input int n);
        if (n > 0 && $urandom_range(0, 99) < 85)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, 31);
    endfunction

    task automatic random_request(input int n);
        int p;
        p = $urandom_range(0, 99);
        if (p < 3)
            send_request(REQ_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
        else if (p < 17)
            send_request(REQ_STEP, $urandom_range(0, 31), $urandom_range(0, 31));
        else if (p < 47)
            send_request(REQ_READ, pick_coord(n), $urandom_range(0, 31));
        else
            send_request(REQ_SET, pick_coord(n), pick_coord(n));
    endtask

    initial
    begin
        // fill a big grid, shrink it, grow it back to see the stored tail,
        // then walk the small and out-of-limit sizes
        int sizes [10] = '{32, 12, 32, 3, 0, 63, 1, 2, 7, 25};

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset size of 21.
        send_request(REQ_READ, 0, 0);
        // glider near the top-left corner
        send_request(REQ_SET, 1, 2);
        send_request(REQ_SET, 2, 3);
        send_request(REQ_SET, 3, 1);
        send_request(REQ_SET, 3, 2);
        send_request(REQ_SET, 3, 3);
        // border cells are legal targets
        send_request(REQ_SET, 0, 0);
        send_request(REQ_SET, 20, 20);
        send_request(REQ_SET, 0, 20);
        // just past the edge, and the far corner of the field
        send_request(REQ_SET, 21, 0);
        send_request(REQ_SET, 0, 21);
        send_request(REQ_SET, 31, 31);
        send_request(REQ_READ, 21, 0);
        send_request(REQ_READ, 31, 31);
        send_request(REQ_STEP, 0, 0);
        send_request(REQ_STEP, 31, 31);
        for (int r = 1; r <= 4; r++)
            send_request(REQ_READ, r, 0);
        send_request(REQ_READ, 0, 0);
        send_request(REQ_CLEAR, 17, 9);
        send_request(REQ_READ, 2, 0);

        for (int ph = 0; ph < 10; ph++)
        begin
            // idle the block before touching the register
            hold_until_drained();
            repeat (DRAIN_CYCLES) @(negedge clk);
            write_size(sizes[ph]);
            live_n = (sizes[ph] > 32) ? 32 : sizes[ph];
            calm = (ph == 2);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                // hold the sender mid-phase until the result side catches up
                if (k == PHASE_WORDS / 2 && ph % 3 == 0)
                    hold_until_drained();
                random_request(live_n);
            end
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
